### hw/rtl/asrb_pkg.sv
// Shared types and fixed widths of the autostereogram row builder.
package asrb_pkg;

  localparam int MODE_W          = 2;
  localparam int TILE_IDX_W      = 6;
  localparam int DEPTH_W         = 8;
  localparam int CFG_W           = 13;
  localparam int COL_W           = 13;
  localparam int CALC_W          = 15;
  localparam int ROW_WIDTH_RESET = 640;
  localparam int FIFO_DEPTH      = 3;
  localparam int FIFO_PTR_W      = 2;
  localparam int FIFO_CNT_W      = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_DEPTH = 2'd1,
    MODE_TAIL  = 2'd2,
    MODE_FRAME = 2'd3
  } mode_t;

  // Control that travels with one request from the accept stage into the select stage.
  typedef struct packed {
    logic produce;
    logic wr;
    logic clr;
    logic src_in;
    logic done;
  } s1_ctrl_t;

endpackage

### hw/rtl/asrb_if.sv
// Valid/ready channel interfaces for the input and result requests.
interface asrb_in_if #(
  parameter int PIXEL_BITS = 24
);
  logic                              valid;
  logic                              ready;
  logic [asrb_pkg::MODE_W-1:0]       mode;
  logic [asrb_pkg::TILE_IDX_W-1:0]   tile_col;
  logic [asrb_pkg::TILE_IDX_W-1:0]   tile_row;
  logic [PIXEL_BITS-1:0]             tile_pixel;
  logic [asrb_pkg::DEPTH_W-1:0]      depth;

  modport source (output valid, mode, tile_col, tile_row, tile_pixel, depth, input ready);
  modport sink   (input valid, mode, tile_col, tile_row, tile_pixel, depth, output ready);
endinterface

interface asrb_out_if #(
  parameter int PIXEL_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic [PIXEL_BITS-1:0]         pixel;
  logic [asrb_pkg::COL_W-1:0]    column;
  logic                          row_done;

  modport source (output valid, pixel, column, row_done, input ready);
  modport sink   (input valid, pixel, column, row_done, output ready);
endinterface

### hw/rtl/asrb_tile_mem.sv
// Texture tile memory: one write port, two registered read ports.
module asrb_tile_mem #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12,
  parameter int DATA_W = 24
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output logic [DATA_W-1:0] rd_data_a,
  output logic [DATA_W-1:0] rd_data_b
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_a_r;
  logic [DATA_W-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

### hw/rtl/asrb_residue_mem.sv
// Per-residue copy memory with valid bits and write-to-read forwarding.
module asrb_residue_mem #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              clr,
  output logic              hit_a,
  output logic [DATA_W-1:0] data_a,
  output logic              hit_b,
  output logic [DATA_W-1:0] data_b
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_a_r;
  logic [DATA_W-1:0] rd_b_r;
  logic [ADDR_W-1:0] addr_a_r;
  logic [ADDR_W-1:0] addr_b_r;
  logic              fwd_a_r;
  logic              fwd_b_r;
  logic [DATA_W-1:0] fwd_data_r;
  logic [DEPTH-1:0]  valid_r;

  // A read issued on the same edge as a write to that entry sees the old word,
  // so the written word is captured and substituted in the next cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r     <= mem[rd_addr_a];
      rd_b_r     <= mem[rd_addr_b];
      addr_a_r   <= rd_addr_a;
      addr_b_r   <= rd_addr_b;
      fwd_a_r    <= wr_en && (wr_addr == rd_addr_a);
      fwd_b_r    <= wr_en && (wr_addr == rd_addr_b);
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (clr) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  assign hit_a  = valid_r[addr_a_r];
  assign hit_b  = valid_r[addr_b_r];
  assign data_a = fwd_a_r ? fwd_data_r : rd_a_r;
  assign data_b = fwd_b_r ? fwd_data_r : rd_b_r;

endmodule

### hw/rtl/asrb_out_fifo.sv
// Small output queue that decouples the result channel from the pipeline.
module asrb_out_fifo #(
  parameter int DATA_W = 38
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  logic [DATA_W-1:0]               push_data,
  input  logic                            pop,
  output logic [DATA_W-1:0]               pop_data,
  output logic                            not_empty,
  output logic [asrb_pkg::FIFO_CNT_W-1:0] count
);

  logic [DATA_W-1:0]               q_r [asrb_pkg::FIFO_DEPTH];
  logic [asrb_pkg::FIFO_PTR_W-1:0] wr_ptr_r;
  logic [asrb_pkg::FIFO_PTR_W-1:0] wr_ptr_nxt;
  logic [asrb_pkg::FIFO_PTR_W-1:0] rd_ptr_r;
  logic [asrb_pkg::FIFO_PTR_W-1:0] rd_ptr_nxt;
  logic [asrb_pkg::FIFO_CNT_W-1:0] cnt_r;
  logic [asrb_pkg::FIFO_CNT_W-1:0] cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == asrb_pkg::FIFO_PTR_W'(asrb_pkg::FIFO_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == asrb_pkg::FIFO_PTR_W'(asrb_pkg::FIFO_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data  = q_r[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign count     = cnt_r;

endmodule

### hw/rtl/autostereogram_row_builder.sv
// Autostereogram row builder: texture tile, per-residue copies and row sequencing.
//
// Usage: the input channel carries one request per item. Mode load writes one
// texture pixel of the square tile; mode depth gives the depth shift of the
// next depth column and returns that column's final pixel; mode tail returns
// one of the TILE_SIZE columns that follow the depth columns; mode frame
// restarts the frame at row zero. The result channel returns pixel, column and
// a row_done flag on the last column of each row. cfg_wr_en/cfg_wr_data set
// the row width and must be written only while the block is idle; the block
// itself does not enforce this. Throughput is one request per cycle while
// in_req.ready is high. Both memories are read at the edge that accepts a
// request and the select and residue write-back take the following cycle,
// so the result is on the result channel right after the next edge.
// Forwarding covers a write-back to an entry that the next request reads.
// Reset clears the column and row counters and all residue valid bits and sets
// the row width to 640; the texture tile holds nothing until loaded.
// When the receiver stalls, results collect in a three-entry output queue and
// in_req.ready drops once the queue and the select stage together hold three.
module autostereogram_row_builder #(
  parameter int TILE_SIZE     = 64,
  parameter int PIXEL_BITS    = 24,
  parameter int MAX_ROW_WIDTH = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [asrb_pkg::CFG_W-1:0] cfg_wr_data,
  asrb_in_if.sink                    in_req,
  asrb_out_if.source                 out_req
);

  localparam int RES_W  = $clog2(TILE_SIZE);
  localparam int TA_W   = $clog2(TILE_SIZE * TILE_SIZE);
  localparam int CNT_W  = $clog2(MAX_ROW_WIDTH + TILE_SIZE);
  localparam int DMOD_N = 2 ** asrb_pkg::DEPTH_W;
  localparam int OUT_W  = PIXEL_BITS + asrb_pkg::COL_W + 1;
  localparam int CW     = asrb_pkg::CALC_W;

  // Depth shift modulo the tile size, worked out at elaboration.
  logic [RES_W-1:0] dmod_tab [DMOD_N];
  for (genvar g = 0; g < DMOD_N; g++) begin : g_dmod
    assign dmod_tab[g] = RES_W'(g % TILE_SIZE);
  end

  logic [asrb_pkg::CFG_W-1:0] row_width_r;
  logic [CNT_W-1:0]           col_r;
  logic [CNT_W-1:0]           col_nxt;
  logic [RES_W-1:0]           res_c_r;
  logic [RES_W-1:0]           res_c_nxt;
  logic [RES_W-1:0]           row_r;
  logic [RES_W-1:0]           row_nxt;
  logic [TA_W-1:0]            row_base_r;
  logic [TA_W-1:0]            row_base_nxt;
  asrb_pkg::s1_ctrl_t         s1_ctrl_r;
  asrb_pkg::s1_ctrl_t         ctrl_nxt;
  logic [RES_W-1:0]           s1_res_c_r;
  logic [CNT_W-1:0]           s1_col_r;

  asrb_pkg::mode_t  mode;
  logic             acc;
  logic             tile_we;
  logic [CW-1:0]    w_eff;
  logic [CW-1:0]    total;
  logic [CW-1:0]    c_ext;
  logic [CW-1:0]    c_inc;
  logic [CW-1:0]    src_sum;
  logic             in_depth_cols;
  logic [RES_W:0]   res_sum;
  logic [RES_W-1:0] res_s;
  logic [TA_W-1:0]  tile_wr_addr;

  logic [PIXEL_BITS-1:0] tile_a;
  logic [PIXEL_BITS-1:0] tile_b;
  logic                  hit_a;
  logic                  hit_b;
  logic [PIXEL_BITS-1:0] res_a;
  logic [PIXEL_BITS-1:0] res_b;
  logic [PIXEL_BITS-1:0] pix;
  logic [PIXEL_BITS-1:0] src_pix;

  logic [asrb_pkg::FIFO_CNT_W-1:0] fifo_cnt;
  logic [asrb_pkg::FIFO_CNT_W:0]   occupancy;
  logic [OUT_W-1:0]                fifo_out;

  assign mode = asrb_pkg::mode_t'(in_req.mode);

  assign occupancy    = {1'b0, fifo_cnt} + {{asrb_pkg::FIFO_CNT_W{1'b0}}, s1_ctrl_r.produce};
  assign in_req.ready = (occupancy < (asrb_pkg::FIFO_CNT_W + 1)'(asrb_pkg::FIFO_DEPTH));
  assign acc          = in_req.valid && in_req.ready;

  // Effective row width: zero acts as one, anything above the maximum is clamped.
  always_comb begin
    if (row_width_r == '0) begin
      w_eff = CW'(1);
    end else if (CW'(row_width_r) > CW'(MAX_ROW_WIDTH)) begin
      w_eff = CW'(MAX_ROW_WIDTH);
    end else begin
      w_eff = CW'(row_width_r);
    end
  end

  assign total         = w_eff + CW'(TILE_SIZE);
  assign c_ext         = CW'(col_r);
  assign c_inc         = c_ext + CW'(1);
  assign src_sum       = c_ext + CW'(in_req.depth);
  assign in_depth_cols = (c_ext < w_eff);

  assign res_sum = {1'b0, res_c_r} + {1'b0, dmod_tab[in_req.depth]};
  assign res_s   = (res_sum >= (RES_W + 1)'(TILE_SIZE)) ?
                   RES_W'(res_sum - (RES_W + 1)'(TILE_SIZE)) : RES_W'(res_sum);

  assign tile_wr_addr = TA_W'(in_req.tile_row) * TA_W'(TILE_SIZE) + TA_W'(in_req.tile_col);

  always_comb begin
    ctrl_nxt = '0;
    tile_we  = 1'b0;
    unique case (mode)
      asrb_pkg::MODE_LOAD: begin
        tile_we = acc && (CW'(in_req.tile_col) < CW'(TILE_SIZE)) &&
                  (CW'(in_req.tile_row) < CW'(TILE_SIZE));
      end
      asrb_pkg::MODE_DEPTH: begin
        ctrl_nxt.produce = in_depth_cols;
        ctrl_nxt.wr      = in_depth_cols && (in_req.depth != '0);
      end
      asrb_pkg::MODE_TAIL: begin
        ctrl_nxt.produce = !in_depth_cols;
      end
      asrb_pkg::MODE_FRAME: begin
        ctrl_nxt.clr = 1'b1;
      end
      default: begin
        ctrl_nxt = '0;
      end
    endcase
    ctrl_nxt.src_in = (src_sum < total);
    ctrl_nxt.done   = ctrl_nxt.produce && (c_inc >= total);
    if (ctrl_nxt.done) begin
      ctrl_nxt.clr = 1'b1;
    end
  end

  // Column, residue and row counters move at the accept edge.
  always_comb begin
    col_nxt      = col_r;
    res_c_nxt    = res_c_r;
    row_nxt      = row_r;
    row_base_nxt = row_base_r;
    if (acc) begin
      if (mode == asrb_pkg::MODE_FRAME) begin
        col_nxt      = '0;
        res_c_nxt    = '0;
        row_nxt      = '0;
        row_base_nxt = '0;
      end else if (ctrl_nxt.done) begin
        col_nxt   = '0;
        res_c_nxt = '0;
        if (row_r == RES_W'(TILE_SIZE - 1)) begin
          row_nxt      = '0;
          row_base_nxt = '0;
        end else begin
          row_nxt      = row_r + 1'b1;
          row_base_nxt = row_base_r + TA_W'(TILE_SIZE);
        end
      end else if (ctrl_nxt.produce) begin
        col_nxt   = CNT_W'(c_inc);
        res_c_nxt = (res_c_r == RES_W'(TILE_SIZE - 1)) ? '0 : res_c_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= asrb_pkg::CFG_W'(asrb_pkg::ROW_WIDTH_RESET);
      col_r       <= '0;
      res_c_r     <= '0;
      row_r       <= '0;
      row_base_r  <= '0;
      s1_ctrl_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        row_width_r <= cfg_wr_data;
      end
      col_r      <= col_nxt;
      res_c_r    <= res_c_nxt;
      row_r      <= row_nxt;
      row_base_r <= row_base_nxt;
      s1_ctrl_r  <= acc ? ctrl_nxt : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_res_c_r <= res_c_r;
      s1_col_r   <= col_r;
    end
  end

  asrb_tile_mem #(
    .DEPTH  (TILE_SIZE * TILE_SIZE),
    .ADDR_W (TA_W),
    .DATA_W (PIXEL_BITS)
  ) u_tile_mem (
    .clk       (clk),
    .wr_en     (tile_we),
    .wr_addr   (tile_wr_addr),
    .wr_data   (in_req.tile_pixel),
    .rd_en     (acc),
    .rd_addr_a (row_base_r + TA_W'(res_c_r)),
    .rd_addr_b (row_base_r + TA_W'(res_s)),
    .rd_data_a (tile_a),
    .rd_data_b (tile_b)
  );

  asrb_residue_mem #(
    .DEPTH  (TILE_SIZE),
    .ADDR_W (RES_W),
    .DATA_W (PIXEL_BITS)
  ) u_residue_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (acc),
    .rd_addr_a (res_c_r),
    .rd_addr_b (res_s),
    .wr_en     (s1_ctrl_r.wr),
    .wr_addr   (s1_res_c_r),
    .wr_data   (src_pix),
    .clr       (s1_ctrl_r.clr),
    .hit_a     (hit_a),
    .data_a    (res_a),
    .hit_b     (hit_b),
    .data_b    (res_b)
  );

  // Beyond the widened row the source falls back to the plain tiling.
  assign pix     = hit_a ? res_a : tile_a;
  assign src_pix = (s1_ctrl_r.src_in && hit_b) ? res_b : tile_b;

  asrb_out_fifo #(
    .DATA_W (OUT_W)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_ctrl_r.produce),
    .push_data ({pix, asrb_pkg::COL_W'(s1_col_r), s1_ctrl_r.done}),
    .pop       (out_req.valid && out_req.ready),
    .pop_data  (fifo_out),
    .not_empty (out_req.valid),
    .count     (fifo_cnt)
  );

  assign out_req.pixel    = fifo_out[OUT_W-1 -: PIXEL_BITS];
  assign out_req.column   = fifo_out[asrb_pkg::COL_W:1];
  assign out_req.row_done = fifo_out[0];

endmodule

### test/tb_autostereogram_row_builder.sv
// Self-checking testbench for the autostereogram row builder with random stalls on both channels.
module tb_autostereogram_row_builder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TILE_SIZE       = 64;
  localparam int PIXEL_BITS      = 24;
  localparam int MAX_ROW_WIDTH   = 4096;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int MAX_REPORTS     = 10;
  localparam int FILLED_ROWS     = 8;

  typedef struct packed {
    logic [PIXEL_BITS-1:0]        pixel;
    logic [asrb_pkg::COL_W-1:0]   column;
    logic                         row_done;
  } row_pixel_t;

  // Tracks tile, residue copies and row position, and queues the pixels each request should yield.
  class stereo_row_scoreboard;
    logic [PIXEL_BITS-1:0]      tile_mem [TILE_SIZE*TILE_SIZE];
    logic [PIXEL_BITS-1:0]      copy_pixel [TILE_SIZE];
    bit                         copy_valid [TILE_SIZE];
    int unsigned                col_cnt;
    int unsigned                tile_line;
    logic [asrb_pkg::CFG_W-1:0] width_reg;
    row_pixel_t                 expected_pixels [$];
    int unsigned                failures;

    function new();
      foreach (copy_valid[i]) copy_valid[i] = 1'b0;
      col_cnt   = 0;
      tile_line = 0;
      width_reg = asrb_pkg::CFG_W'(asrb_pkg::ROW_WIDTH_RESET);
      failures  = 0;
    endfunction

    function void set_width(logic [asrb_pkg::CFG_W-1:0] value);
      width_reg = value;
    endfunction

    function int unsigned active_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_ROW_WIDTH) return MAX_ROW_WIDTH;
      return width_reg;
    endfunction

    function logic [PIXEL_BITS-1:0] tiling(int unsigned col);
      return tile_mem[tile_line * TILE_SIZE + col % TILE_SIZE];
    endfunction

    function logic [PIXEL_BITS-1:0] current(int unsigned col);
      if (copy_valid[col % TILE_SIZE]) return copy_pixel[col % TILE_SIZE];
      return tiling(col);
    endfunction

    function void clear_row();
      foreach (copy_valid[i]) copy_valid[i] = 1'b0;
      col_cnt = 0;
    endfunction

    function void note_request(asrb_pkg::mode_t m, logic [asrb_pkg::TILE_IDX_W-1:0] tc,
                               logic [asrb_pkg::TILE_IDX_W-1:0] tr,
                               logic [PIXEL_BITS-1:0] px, logic [asrb_pkg::DEPTH_W-1:0] d);
      int unsigned w;
      int unsigned total;
      int unsigned c;
      int unsigned src;
      row_pixel_t  r;
      w     = active_width();
      total = w + TILE_SIZE;
      c     = col_cnt;
      case (m)
        asrb_pkg::MODE_LOAD: begin
          if (tc < TILE_SIZE && tr < TILE_SIZE) tile_mem[tr * TILE_SIZE + tc] = px;
          return;
        end
        asrb_pkg::MODE_FRAME: begin
          clear_row();
          tile_line = 0;
          return;
        end
        asrb_pkg::MODE_DEPTH: if (c >= w) return;
        asrb_pkg::MODE_TAIL: if (c < w) return;
      endcase
      r.pixel  = current(c);
      r.column = asrb_pkg::COL_W'(c);
      if (m == asrb_pkg::MODE_DEPTH && d != 0) begin
        src = c + d;
        // Beyond the widened row the source falls back to the plain tiling.
        copy_pixel[c % TILE_SIZE] = (src < total) ? current(src) : tiling(src);
        copy_valid[c % TILE_SIZE] = 1'b1;
      end
      r.row_done = (c + 1 >= total);
      if (r.row_done) begin
        clear_row();
        tile_line = (tile_line + 1) % TILE_SIZE;
      end else begin
        col_cnt = c + 1;
      end
      expected_pixels.push_back(r);
    endfunction

    function void check_pixel(logic [PIXEL_BITS-1:0] pix, logic [asrb_pkg::COL_W-1:0] col,
                              logic done);
      row_pixel_t e;
      if (expected_pixels.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected result: pixel %h column %0d row_done %b", pix, col, done);
        return;
      end
      e = expected_pixels.pop_front();
      if (e.pixel !== pix || e.column !== col || e.row_done !== done) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("mismatch: expected pixel %h column %0d row_done %b, got %h %0d %b",
                   e.pixel, e.column, e.row_done, pix, col, done);
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [asrb_pkg::CFG_W-1:0] cfg_wr_data;
  bit                         burst;
  bit                         hold_off_due;
  int unsigned                useful_items;

  stereo_row_scoreboard row_check = new();

  asrb_in_if  #(.PIXEL_BITS(PIXEL_BITS)) in_ch ();
  asrb_out_if #(.PIXEL_BITS(PIXEL_BITS)) out_ch ();

  autostereogram_row_builder #(
    .TILE_SIZE    (TILE_SIZE),
    .PIXEL_BITS   (PIXEL_BITS),
    .MAX_ROW_WIDTH(MAX_ROW_WIDTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_req     (in_ch),
    .out_req    (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      row_check.note_request(asrb_pkg::mode_t'(in_ch.mode), in_ch.tile_col, in_ch.tile_row,
                             in_ch.tile_pixel, in_ch.depth);
    if (rst_n && out_ch.valid && out_ch.ready)
      row_check.check_pixel(out_ch.pixel, out_ch.column, out_ch.row_done);
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(15, 30);
  endfunction

  function automatic logic [asrb_pkg::TILE_IDX_W-1:0] rand_idx();
    return asrb_pkg::TILE_IDX_W'($urandom);
  endfunction

  function automatic logic [PIXEL_BITS-1:0] rand_pixel();
    return PIXEL_BITS'($urandom);
  endfunction

  function automatic logic [asrb_pkg::DEPTH_W-1:0] pick_depth();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return '0;
    if (r < 65) return asrb_pkg::DEPTH_W'($urandom_range(1, TILE_SIZE));
    if (r < 92) return asrb_pkg::DEPTH_W'($urandom_range(1, 255));
    return (r < 96) ? 8'd255 : 8'd128;
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(input asrb_pkg::mode_t m,
                              input logic [asrb_pkg::TILE_IDX_W-1:0] tc,
                              input logic [asrb_pkg::TILE_IDX_W-1:0] tr,
                              input logic [PIXEL_BITS-1:0] px,
                              input logic [asrb_pkg::DEPTH_W-1:0] d);
    int unsigned gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= m;
    in_ch.tile_col   <= tc;
    in_ch.tile_row   <= tr;
    in_ch.tile_pixel <= px;
    in_ch.depth      <= d;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_noise_load();
    send_request(asrb_pkg::MODE_LOAD, rand_idx(), rand_idx(), rand_pixel(), pick_depth());
    useful_items++;
  endtask

  task automatic send_frame();
    send_request(asrb_pkg::MODE_FRAME, rand_idx(), rand_idx(), rand_pixel(), pick_depth());
    useful_items++;
  endtask

  task automatic send_ignored(input asrb_pkg::mode_t m);
    send_request(m, rand_idx(), rand_idx(), rand_pixel(), pick_depth());
  endtask

  // One row of depth pixels and tail ticks, with stray requests mixed in.
  task automatic run_row(input int unsigned w, input bit allow_frames);
    int unsigned k;
    burst = ($urandom_range(0, 3) == 0);
    // Only the first texture rows are loaded, so the frame restarts before the row leaves them.
    if (row_check.tile_line >= FILLED_ROWS) send_frame();
    else if (allow_frames && $urandom_range(0, 19) == 0) send_frame();
    for (k = 0; k < w; k++) begin
      if ($urandom_range(0, 39) == 0) send_noise_load();
      if ($urandom_range(0, 59) == 0) send_ignored(asrb_pkg::MODE_TAIL);
      if (allow_frames && $urandom_range(0, 299) == 0) begin
        send_frame();
        return;
      end
      send_request(asrb_pkg::MODE_DEPTH, rand_idx(), rand_idx(), rand_pixel(), pick_depth());
      useful_items++;
    end
    if ($urandom_range(0, 3) == 0) send_ignored(asrb_pkg::MODE_DEPTH);
    for (k = 0; k < TILE_SIZE; k++) begin
      if ($urandom_range(0, 39) == 0) send_noise_load();
      if ($urandom_range(0, 79) == 0) send_ignored(asrb_pkg::MODE_DEPTH);
      send_request(asrb_pkg::MODE_TAIL, rand_idx(), rand_idx(), rand_pixel(), pick_depth());
      useful_items++;
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (row_check.expected_pixels.size() > 0) @(negedge clk);
    // Requests that give no result may still be in the pipeline.
    repeat (8) @(negedge clk);
  endtask

  task automatic run_phase(input logic [asrb_pkg::CFG_W-1:0] width_val,
                           input int unsigned budget,
                           input bit write_cfg, input bit allow_frames);
    int unsigned start;
    int unsigned w;
    if (write_cfg) begin
      wait_idle();
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= width_val;
      row_check.set_width(width_val);
      @(negedge clk);
      cfg_wr_en   <= 1'b0;
    end
    w = (width_val == 0) ? 1 : (width_val > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH : width_val;
    start = useful_items;
    do begin
      run_row(w, allow_frames);
    end while (useful_items - start < budget);
  endtask

  initial begin : result_sink
    int unsigned len;
    int unsigned k;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_off_due) begin
        hold_off_due = 1'b0;
        out_ch.ready <= 1'b0;
        len = HOLD_OFF_CYCLES;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
      end else begin
        out_ch.ready <= 1'b1;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 8);
      end
      // A requested long hold-off cuts the current stretch short.
      for (k = 0; k < len && !hold_off_due; k++) @(negedge clk);
    end
  end

  initial begin : stimulus
    int i;
    in_ch.valid      = 1'b0;
    in_ch.mode       = asrb_pkg::MODE_LOAD;
    in_ch.tile_col   = '0;
    in_ch.tile_row   = '0;
    in_ch.tile_pixel = '0;
    in_ch.depth      = '0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    rst_n            = 1'b0;
    burst            = 1'b0;
    hold_off_due     = 1'b0;
    useful_items     = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Fill the texture rows that the rows below walk through so every read is defined.
    for (i = 0; i < FILLED_ROWS * TILE_SIZE; i++)
      send_request(asrb_pkg::MODE_LOAD, i[5:0], i[11:6], rand_pixel(), pick_depth());

    // Directed requests at the reset row width.
    send_request(asrb_pkg::MODE_LOAD, 6'd63, 6'd63, 24'hFFFFFF, 8'd255);
    send_request(asrb_pkg::MODE_LOAD, 6'd0, 6'd0, 24'h000000, 8'd0);
    send_request(asrb_pkg::MODE_LOAD, 6'd1, 6'd0, 24'hFFFFFF, 8'd170);
    send_request(asrb_pkg::MODE_LOAD, 6'd42, 6'd21, 24'hA5A5A5, 8'd85);
    send_request(asrb_pkg::MODE_TAIL, 6'd63, 6'd63, 24'hFFFFFF, 8'd255);
    send_request(asrb_pkg::MODE_DEPTH, 6'd0, 6'd0, 24'h000000, 8'd0);
    send_request(asrb_pkg::MODE_DEPTH, 6'd63, 6'd63, 24'hFFFFFF, 8'd255);
    send_request(asrb_pkg::MODE_DEPTH, 6'd0, 6'd0, 24'h000000, 8'd1);
    send_request(asrb_pkg::MODE_DEPTH, 6'd0, 6'd0, 24'h000000, 8'd63);
    send_request(asrb_pkg::MODE_DEPTH, 6'd0, 6'd0, 24'h000000, 8'd64);
    send_request(asrb_pkg::MODE_DEPTH, 6'd0, 6'd0, 24'h000000, 8'd0);
    send_request(asrb_pkg::MODE_DEPTH, 6'd0, 6'd0, 24'h000000, 8'd128);
    send_request(asrb_pkg::MODE_FRAME, 6'd0, 6'd0, 24'h000000, 8'd0);
    send_request(asrb_pkg::MODE_DEPTH, 6'd0, 6'd0, 24'h000000, 8'd2);
    send_request(asrb_pkg::MODE_DEPTH, 6'd0, 6'd0, 24'h000000, 8'd0);
    send_request(asrb_pkg::MODE_FRAME, 6'd63, 6'd63, 24'hFFFFFF, 8'd255);

    run_phase(13'd1, 65, 1'b1, 1'b1);
    // The long receiver hold-off lands while rows are streaming in.
    hold_off_due = 1'b1;
    run_phase(13'd1, 130, 1'b0, 1'b1);
    run_phase(13'd2, 132, 1'b1, 1'b1);
    run_phase(13'd63, 127, 1'b1, 1'b1);
    run_phase(13'd64, 128, 1'b1, 1'b1);
    run_phase(13'd65, 129, 1'b1, 1'b1);
    run_phase(13'd0, 195, 1'b1, 1'b0);
    run_phase(asrb_pkg::CFG_W'($urandom_range(3, 200)), 200, 1'b1, 1'b1);
    run_phase(asrb_pkg::CFG_W'($urandom_range(3, 40)), 150, 1'b1, 1'b1);

    in_ch.valid <= 1'b0;
    for (i = 0; i < 20000 && row_check.expected_pixels.size() > 0; i++) @(negedge clk);
    repeat (10) @(negedge clk);
    if (row_check.failures == 0 && row_check.expected_pixels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (row_check.expected_pixels.size() > 0)
        $display("%0d expected results never arrived", row_check.expected_pixels.size());
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #40000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
